// File: hdl/double_ended_queue_macros.svh
// assertion macros for the double-ended queue
// no dependencies; included by the top level
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication, checked outside reset
`define DEQ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define DEQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/deq_pkg.sv
// shared types, sizes and codes for the double-ended queue
// no dependencies
package deq_pkg;

   localparam int DEPTH       = 1024;
   localparam int DATA_WIDTH  = 32;
   localparam int ADDR_WIDTH  = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   localparam int OP_WIDTH     = 2;
   localparam int VALUE_WIDTH  = 32;
   localparam int INDEX_WIDTH  = 10;
   localparam int ECOUNT_WIDTH = 11;
   localparam int STATUS_WIDTH = 2;

   typedef logic [OP_WIDTH-1:0]     op_type;
   typedef logic [VALUE_WIDTH-1:0]  value_type;
   typedef logic [INDEX_WIDTH-1:0]  index_type;
   typedef logic [ECOUNT_WIDTH-1:0] ecount_type;
   typedef logic [STATUS_WIDTH-1:0] status_type;

   localparam op_type OP_PUSH_BACK  = 2'd0;
   localparam op_type OP_PUSH_FRONT = 2'd1;
   localparam op_type OP_READ       = 2'd2;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_RANGE = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ACCESS,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic latch_req;
      logic access;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// File: hdl/deq_req_if.sv
// request channel: operation, value and index with valid/ready
// depends on deq_pkg
interface deq_req_if;
   import deq_pkg::*;

   logic      valid;
   logic      ready;
   op_type    operation;
   value_type value;
   index_type index;

   modport source (output valid, output operation, output value, output index,
                   input ready);
   modport sink   (input valid, input operation, input value, input index,
                   output ready);
endinterface

// File: hdl/deq_rsp_if.sv
// result channel: read, front and back values, count and status with valid/ready
// depends on deq_pkg
interface deq_rsp_if;
   import deq_pkg::*;

   logic       valid;
   logic       ready;
   value_type  read_value;
   value_type  front_value;
   value_type  back_value;
   ecount_type element_count;
   status_type status;

   modport source (output valid, output read_value, output front_value,
                   output back_value, output element_count, output status,
                   input ready);
   modport sink   (input valid, input read_value, input front_value,
                   input back_value, input element_count, input status,
                   output ready);
endinterface

// File: hdl/deq_controller.sv
// sequencer for the double-ended queue: accept, store access, result load
// depends on deq_pkg
module deq_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  deq_pkg::dp_status_type dp_status,
   output deq_pkg::cmd_type       cmd
);
   import deq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_ACCESS;
         end
         S_ACCESS: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (dp_status.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            cmd.latch_req = req_valid;
         end
         S_ACCESS: begin
            cmd.access = 1'b1;
         end
         S_FINISH: begin
            cmd.load_rsp = dp_status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: hdl/deq_datapath.sv
// ring store, head pointer, count, front/back copies and result register
// depends on deq_pkg
module deq_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  deq_pkg::cmd_type       cmd,
   output deq_pkg::dp_status_type dp_status,
   input  deq_pkg::op_type        req_operation,
   input  deq_pkg::value_type     req_value,
   input  deq_pkg::index_type     req_index,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output deq_pkg::value_type     rsp_read_value,
   output deq_pkg::value_type     rsp_front_value,
   output deq_pkg::value_type     rsp_back_value,
   output deq_pkg::ecount_type    rsp_element_count,
   output deq_pkg::status_type    rsp_status
);
   import deq_pkg::*;

   typedef logic [ADDR_WIDTH-1:0]  addr_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [DATA_WIDTH-1:0]  data_type;

   // ring position: base + offset wrapped once, both below DEPTH
   function automatic addr_type ring_add(input addr_type base, input addr_type offset);
      logic [ADDR_WIDTH:0] sum;
      sum = (ADDR_WIDTH+1)'(base) + (ADDR_WIDTH+1)'(offset);
      if (sum >= (ADDR_WIDTH+1)'(DEPTH)) sum = sum - (ADDR_WIDTH+1)'(DEPTH);
      return addr_type'(sum);
   endfunction

   data_type store_mem [DEPTH];

   op_type     op_ff;
   data_type   value_ff;
   index_type  index_ff;
   addr_type   head_ff;
   count_type  count_ff;
   data_type   front_ff;
   data_type   back_ff;
   data_type   rd_data_ff;
   logic       rd_hit_ff;
   status_type status_ff;
   logic       rsp_valid_ff;
   value_type  rsp_read_value_ff;
   value_type  rsp_front_value_ff;
   value_type  rsp_back_value_ff;
   ecount_type rsp_element_count_ff;
   status_type rsp_status_ff;

   logic       is_push;
   logic       is_read;
   logic       full;
   logic       empty;
   logic       in_range;
   logic       do_write;
   addr_type   head_dec;
   addr_type   rd_addr;
   addr_type   wr_addr;
   status_type status_in;

   always_comb begin
      is_push  = (op_ff == OP_PUSH_BACK) || (op_ff == OP_PUSH_FRONT);
      is_read  = (op_ff == OP_READ);
      full     = (count_ff == count_type'(DEPTH));
      empty    = (count_ff == '0);
      in_range = (32'(index_ff) < 32'(count_ff));
      do_write = cmd.access && is_push && !full;
      head_dec = (head_ff == '0) ? addr_type'(DEPTH - 1) : head_ff - addr_type'(1);
      rd_addr  = ring_add(head_ff, addr_type'(index_ff));
      wr_addr  = (op_ff == OP_PUSH_BACK) ? ring_add(head_ff, addr_type'(count_ff))
                                         : head_dec;
      if (is_push && full) status_in = ST_FULL;
      else if (is_read && !in_range) status_in = ST_RANGE;
      else status_in = ST_OK;
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff    <= req_operation;
         value_ff <= data_type'(req_value);
         index_ff <= req_index;
      end
   end

   // ring store: one write and one registered read
   always_ff @(posedge clock) begin
      if (do_write) store_mem[wr_addr] <= value_ff;
      if (cmd.access) rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (do_write) begin
         count_ff <= count_ff + count_type'(1);
         if (op_ff == OP_PUSH_FRONT) head_ff <= head_dec;
      end
   end

   // front and back copies, only shown while the queue holds something; status and read hit captured at store access
   always_ff @(posedge clock) begin
      if (do_write) begin
         if (op_ff == OP_PUSH_FRONT) begin
            front_ff <= value_ff;
            if (empty) back_ff <= value_ff;
         end else begin
            back_ff <= value_ff;
            if (empty) front_ff <= value_ff;
         end
      end
      if (cmd.access) begin
         status_ff <= status_in;
         rd_hit_ff <= is_read && in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_read_value_ff    <= rd_hit_ff ? value_type'(rd_data_ff) : '0;
         rsp_front_value_ff   <= empty ? '0 : value_type'(front_ff);
         rsp_back_value_ff    <= empty ? '0 : value_type'(back_ff);
         rsp_element_count_ff <= ecount_type'(count_ff);
         rsp_status_ff        <= status_ff;
      end
   end

   assign dp_status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_value     = rsp_read_value_ff;
   assign rsp_front_value    = rsp_front_value_ff;
   assign rsp_back_value     = rsp_back_value_ff;
   assign rsp_element_count  = rsp_element_count_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

// File: hdl/double_ended_queue.sv
// double-ended queue: push back, push front, checked read by index
// result: the request is captured, the store is accessed, then the result is loaded once the output register is free
// requests are taken one at a time, each passing through the accept/access/load sequence
// a request can be taken while the previous result still waits in the output register
// reset (synchronous, active high) empties the queue; store contents are not cleared
// depends on deq_pkg, deq_req_if, deq_rsp_if, deq_controller, deq_datapath
`include "double_ended_queue_macros.svh"

module double_ended_queue (
   input  logic   clock,
   input  logic   reset,
   deq_req_if.sink   req_ch,
   deq_rsp_if.source rsp_ch
);
   import deq_pkg::*;

   cmd_type       cmd;
   dp_status_type dp_status;

   deq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   deq_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .dp_status         (dp_status),
      .req_operation     (req_ch.operation),
      .req_value         (req_ch.value),
      .req_index         (req_ch.index),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_read_value    (rsp_ch.read_value),
      .rsp_front_value   (rsp_ch.front_value),
      .rsp_back_value    (rsp_ch.back_value),
      .rsp_element_count (rsp_ch.element_count),
      .rsp_status        (rsp_ch.status)
   );

   `DEQ_ASSERT_NEXT(a_accept_access, clock, reset, req_ch.valid && req_ch.ready, cmd.access && !req_ch.ready, "accepted request not followed by store access")
   `DEQ_ASSERT_NEXT(a_load_valid, clock, reset, cmd.load_rsp, rsp_ch.valid, "result load did not raise valid")
   `DEQ_ASSERT_SAME(a_full_count, clock, reset, rsp_ch.valid && (rsp_ch.status == ST_FULL), rsp_ch.element_count == ecount_type'(DEPTH), "push dropped while not full")
   `DEQ_ASSERT_SAME(a_range_zero, clock, reset, rsp_ch.valid && (rsp_ch.status == ST_RANGE), rsp_ch.read_value == '0, "out of range read returned data")

endmodule
